// ----- hw/rtl/olist_pkg.sv -----
// Shared types, constants and command/status structs for the ordered list engine.
`timescale 1ns / 1ps
package olist_pkg;

  localparam int DEPTH = 64;
  localparam int IW    = $clog2(DEPTH);
  localparam int CW    = $clog2(DEPTH + 1);
  localparam int CMD_W = 4;
  localparam int VAL_W = 32;
  localparam int POS_W = 7;
  localparam int CMPW  = POS_W + 1;

  // free slot search: groups of eight
  localparam int GW    = 8;
  localparam int GIW   = $clog2(GW);
  localparam int NGRP  = (DEPTH + GW - 1) / GW;
  localparam int NGIW  = (NGRP > 1) ? $clog2(NGRP) : 1;

  typedef enum logic [CMD_W-1:0] {
    CMD_INS_FIRST = 4'd0,
    CMD_INS_LAST  = 4'd1,
    CMD_INS_POS   = 4'd2,
    CMD_DEL_FIRST = 4'd3,
    CMD_DEL_LAST  = 4'd4,
    CMD_DEL_POS   = 4'd5,
    CMD_DUMP      = 4'd6,
    CMD_COUNT     = 4'd7,
    CMD_EVEN      = 4'd8,
    CMD_ODD       = 4'd9,
    CMD_SUM       = 4'd10,
    CMD_MAX       = 4'd11,
    CMD_MIN       = 4'd12,
    CMD_SEARCH    = 4'd13,
    CMD_FREQ      = 4'd14,
    CMD_UNUSED    = 4'd15
  } cmd_e;

  typedef enum logic [1:0] {
    ST_OK     = 2'd0,
    ST_BADPOS = 2'd1,
    ST_EMPTY  = 2'd2,
    ST_FULL   = 2'd3
  } status_e;

  typedef enum logic {RD_HEAD, RD_LINK} rd_sel_t;
  typedef enum logic [1:0] {REM_POS2, REM_CNT2, REM_CNT1} rem_sel_t;
  typedef enum logic [1:0] {LA_SLOT, LA_TAIL, LA_CUR} la_sel_t;
  typedef enum logic [1:0] {LD_HEAD, LD_SLOT, LD_RDLINK} ld_sel_t;
  typedef enum logic [2:0] {
    UPD_NONE, UPD_INS_FIRST, UPD_INS_LAST, UPD_INS_MID,
    UPD_DEL_HEAD, UPD_DEL_TAIL, UPD_DEL_MID, UPD_EMPTY
  } upd_t;
  typedef enum logic [2:0] {EM_ZERO, EM_ACC, EM_FOUND, EM_DUMP, EM_COUNT} em_sel_t;

  typedef struct packed {
    logic     capture;
    logic     rd_en;
    rd_sel_t  rd_sel;
    logic     cur_load;
    logic     aux_load;
    logic     rem_load;
    rem_sel_t rem_sel;
    logic     rem_dec;
    logic     lw_en;
    la_sel_t  la_sel;
    ld_sel_t  ld_sel;
    logic     vw_en;
    upd_t     upd;
    logic     acc_clr;
    logic     acc_step;
    logic     emit;
    em_sel_t  em_sel;
    status_e  em_status;
    logic     em_last;
  } dp_cmd_t;

  typedef struct packed {
    logic [CMD_W-1:0] cmd;
    logic cnt_zero;
    logic cnt_full;
    logic cnt_le1;
    logic ins_pos_bad;
    logic del_pos_bad;
    logic pos_first;
    logic pos_after_last;
    logic pos_last;
    logic rem_zero;
    logic out_free;
  } dp_stat_t;

endpackage

// ----- hw/rtl/olist_dp.sv -----
// Datapath: node store, list pointers, free map, slot finder, accumulator, result register.
`timescale 1ns / 1ps
module olist_dp (
  input  logic                              clk,
  input  logic                              rst,
  input  olist_pkg::dp_cmd_t                c,
  output olist_pkg::dp_stat_t               st,
  input  logic [olist_pkg::CMD_W-1:0]       command,
  input  logic signed [olist_pkg::VAL_W-1:0] value,
  input  logic [olist_pkg::POS_W-1:0]       position,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic signed [olist_pkg::VAL_W-1:0] result_value,
  output logic                              found,
  output logic [1:0]                        status,
  output logic                              last_result
);
  import olist_pkg::*;

  logic [VAL_W-1:0] vals  [DEPTH];
  logic [IW-1:0]    links [DEPTH];

  logic [CMD_W-1:0] cmd_q;
  logic [VAL_W-1:0] val_q;
  logic [POS_W-1:0] pos_q;

  logic [IW-1:0]    head, tail, cur, aux, slot;
  logic [CW-1:0]    count, rem;
  logic [DEPTH-1:0] free_map;
  logic [VAL_W-1:0] rd_val, acc;
  logic [IW-1:0]    rd_link;
  logic             acc_first;

  logic [IW-1:0]    rd_addr, la, ld;

  logic [NGRP*GW-1:0] fpad;
  logic [NGRP-1:0]    grp_any;
  logic [GIW-1:0]     grp_idx [NGRP];
  logic [NGRP-1:0]    grp_any_c;
  logic [GIW-1:0]     grp_idx_c [NGRP];
  logic [NGIW-1:0]    gsel;
  logic [NGIW+GIW-1:0] slot_c;

  logic [CMPW-1:0] pos_w, cnt_w;

  // item capture
  always_ff @(posedge clk) begin
    if (c.capture) begin
      cmd_q <= command;
      val_q <= value;
      pos_q <= position;
    end
  end

  // slot finder, stage one: lowest free bit in each group
  assign fpad = (NGRP*GW)'(free_map);
  always_comb begin
    for (int g = 0; g < NGRP; g++) begin
      grp_any_c[g] = |fpad[g*GW +: GW];
      grp_idx_c[g] = '0;
      for (int b = GW - 1; b >= 0; b--) begin
        if (fpad[g*GW + b]) grp_idx_c[g] = GIW'(b);
      end
    end
  end

  always_ff @(posedge clk) begin
    grp_any <= grp_any_c;
    grp_idx <= grp_idx_c;
  end

  // stage two: lowest group with a free bit
  always_comb begin
    gsel = '0;
    for (int g = NGRP - 1; g >= 0; g--) begin
      if (grp_any[g]) gsel = NGIW'(g);
    end
    slot_c = {gsel, grp_idx[gsel]};
  end

  always_ff @(posedge clk) begin
    slot <= IW'(slot_c);
  end

  // node store
  assign rd_addr = (c.rd_sel == RD_LINK) ? rd_link : head;

  always_comb begin
    case (c.la_sel)
      LA_TAIL: la = tail;
      LA_CUR:  la = cur;
      default: la = slot;
    endcase
    case (c.ld_sel)
      LD_SLOT:   ld = slot;
      LD_RDLINK: ld = rd_link;
      default:   ld = head;
    endcase
  end

  always_ff @(posedge clk) begin
    if (c.lw_en) links[la] <= ld;
    if (c.vw_en) vals[slot] <= val_q;
    if (c.rd_en) begin
      rd_val  <= vals[rd_addr];
      rd_link <= links[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (c.rd_en && c.cur_load) cur <= rd_addr;
    if (c.aux_load) aux <= rd_link;
    if (c.rem_load) begin
      case (c.rem_sel)
        REM_POS2: rem <= CW'(pos_q) - CW'(2);
        REM_CNT2: rem <= count - CW'(2);
        default:  rem <= count - CW'(1);
      endcase
    end else if (c.rem_dec) begin
      rem <= rem - CW'(1);
    end
  end

  // list pointers and free map
  always_ff @(posedge clk) begin
    if (rst) begin
      head     <= '0;
      tail     <= '0;
      count    <= '0;
      free_map <= {DEPTH{1'b1}};
    end else begin
      case (c.upd)
        UPD_INS_FIRST: begin
          head <= slot;
          if (count == '0) tail <= slot;
          free_map[slot] <= 1'b0;
          count <= count + CW'(1);
        end
        UPD_INS_LAST: begin
          tail <= slot;
          if (count == '0) head <= slot;
          free_map[slot] <= 1'b0;
          count <= count + CW'(1);
        end
        UPD_INS_MID: begin
          free_map[slot] <= 1'b0;
          count <= count + CW'(1);
        end
        UPD_DEL_HEAD: begin
          head <= rd_link;
          free_map[head] <= 1'b1;
          count <= count - CW'(1);
        end
        UPD_DEL_TAIL: begin
          tail <= cur;
          free_map[tail] <= 1'b1;
          count <= count - CW'(1);
        end
        UPD_DEL_MID: begin
          free_map[aux] <= 1'b1;
          count <= count - CW'(1);
        end
        UPD_EMPTY: begin
          free_map[head] <= 1'b1;
          head  <= '0;
          tail  <= '0;
          count <= '0;
        end
        default: ;
      endcase
    end
  end

  // accumulator for queries
  always_ff @(posedge clk) begin
    if (c.acc_clr) begin
      acc       <= '0;
      acc_first <= 1'b1;
    end else if (c.acc_step) begin
      acc_first <= 1'b0;
      case (cmd_q)
        CMD_EVEN: if (!rd_val[0]) acc <= acc + 32'd1;
        CMD_ODD:  if (rd_val[0]) acc <= acc + 32'd1;
        CMD_SUM:  acc <= acc + rd_val;
        CMD_MAX:  if (acc_first || ($signed(acc) < $signed(rd_val))) acc <= rd_val;
        CMD_MIN:  if (acc_first || ($signed(rd_val) < $signed(acc))) acc <= rd_val;
        default:  if (rd_val == val_q) acc <= acc + 32'd1;
      endcase
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (c.emit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (c.emit) begin
      status      <= c.em_status;
      last_result <= c.em_last;
      found       <= (c.em_sel == EM_FOUND) && (acc != '0);
      case (c.em_sel)
        EM_ACC:   result_value <= acc;
        EM_DUMP:  result_value <= rd_val;
        EM_COUNT: result_value <= VAL_W'(count);
        default:  result_value <= '0;
      endcase
    end
  end

  // status to the controller
  assign pos_w = CMPW'(pos_q);
  assign cnt_w = CMPW'(count);

  always_comb begin
    st.cmd            = cmd_q;
    st.cnt_zero       = (count == '0);
    st.cnt_full       = (count == CW'(DEPTH));
    st.cnt_le1        = (count <= CW'(1));
    st.ins_pos_bad    = (pos_w == '0) || (pos_w > cnt_w + CMPW'(1));
    st.del_pos_bad    = (pos_w == '0) || (pos_w > cnt_w);
    st.pos_first      = (pos_w == CMPW'(1));
    st.pos_after_last = (pos_w == cnt_w + CMPW'(1));
    st.pos_last       = (pos_w == cnt_w);
    st.rem_zero       = (rem == '0);
    st.out_free       = !out_valid || out_ready;
  end

endmodule

// ----- hw/rtl/olist_ctrl.sv -----
// Controller: sequences list edits, walks and result transfers.
`timescale 1ns / 1ps
module olist_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  olist_pkg::dp_stat_t st,
  output olist_pkg::dp_cmd_t  c
);
  import olist_pkg::*;

  typedef enum logic [13:0] {
    S_IDLE      = 14'b00000000000001,
    S_DECIDE    = 14'b00000000000010,
    S_FIND      = 14'b00000000000100,
    S_SLOT      = 14'b00000000001000,
    S_INS_A     = 14'b00000000010000,
    S_INS_B     = 14'b00000000100000,
    S_LINK_TH   = 14'b00000001000000,
    S_WALK      = 14'b00000010000000,
    S_DEL_T     = 14'b00000100000000,
    S_DROP_HEAD = 14'b00001000000000,
    S_SCAN      = 14'b00010000000000,
    S_DUMP      = 14'b00100000000000,
    S_EMIT      = 14'b01000000000000,
    S_SPARE     = 14'b10000000000000
  } state_t;

  typedef enum logic [2:0] {
    OP_INS_FIRST, OP_INS_LAST, OP_INS_MID, OP_DEL_LAST, OP_DEL_MID
  } op_t;

  state_t  state, state_next;
  op_t     op, op_next;
  em_sel_t em_sel, em_sel_next;
  status_e em_st, em_st_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= S_IDLE;
      op     <= OP_INS_FIRST;
      em_sel <= EM_ZERO;
      em_st  <= ST_OK;
    end else begin
      state  <= state_next;
      op     <= op_next;
      em_sel <= em_sel_next;
      em_st  <= em_st_next;
    end
  end

  always_comb begin
    state_next  = state;
    op_next     = op;
    em_sel_next = em_sel;
    em_st_next  = em_st;
    c           = '0;
    in_ready    = 1'b0;
    case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          c.capture  = 1'b1;
          state_next = S_DECIDE;
        end
      end

      S_DECIDE: begin
        state_next  = S_EMIT;
        em_sel_next = EM_ZERO;
        em_st_next  = ST_OK;
        case (st.cmd)
          CMD_INS_FIRST, CMD_INS_LAST: begin
            if (st.cnt_full) begin
              em_st_next = ST_FULL;
            end else begin
              op_next    = (st.cmd == CMD_INS_FIRST) ? OP_INS_FIRST : OP_INS_LAST;
              state_next = S_FIND;
            end
          end
          CMD_INS_POS: begin
            if (st.ins_pos_bad) begin
              em_st_next = ST_BADPOS;
            end else if (st.cnt_full) begin
              em_st_next = ST_FULL;
            end else begin
              op_next    = st.pos_first ? OP_INS_FIRST :
                           st.pos_after_last ? OP_INS_LAST : OP_INS_MID;
              state_next = S_FIND;
            end
          end
          CMD_DEL_FIRST, CMD_DEL_LAST, CMD_DEL_POS: begin
            if (st.cnt_zero) begin
              em_st_next = ST_EMPTY;
            end else if ((st.cmd == CMD_DEL_POS) && st.del_pos_bad) begin
              em_st_next = ST_BADPOS;
            end else if (st.cnt_le1) begin
              c.upd = UPD_EMPTY;
            end else if ((st.cmd == CMD_DEL_FIRST) ||
                         ((st.cmd == CMD_DEL_POS) && st.pos_first)) begin
              c.rd_en    = 1'b1;
              c.cur_load = 1'b1;
              state_next = S_DROP_HEAD;
            end else begin
              c.rd_en    = 1'b1;
              c.cur_load = 1'b1;
              c.rem_load = 1'b1;
              if ((st.cmd == CMD_DEL_POS) && !st.pos_last) begin
                c.rem_sel = REM_POS2;
                op_next   = OP_DEL_MID;
              end else begin
                c.rem_sel = REM_CNT2;
                op_next   = OP_DEL_LAST;
              end
              state_next = S_WALK;
            end
          end
          CMD_DUMP: begin
            if (st.cnt_zero) begin
              em_st_next = ST_EMPTY;
            end else begin
              c.rd_en    = 1'b1;
              c.cur_load = 1'b1;
              c.rem_load = 1'b1;
              c.rem_sel  = REM_CNT1;
              state_next = S_DUMP;
            end
          end
          CMD_COUNT: begin
            if (st.cnt_zero) em_st_next = ST_EMPTY;
            else em_sel_next = EM_COUNT;
          end
          CMD_EVEN, CMD_ODD, CMD_SUM, CMD_MAX, CMD_MIN, CMD_SEARCH, CMD_FREQ: begin
            if (st.cnt_zero) begin
              em_st_next = ST_EMPTY;
            end else begin
              c.rd_en    = 1'b1;
              c.cur_load = 1'b1;
              c.rem_load = 1'b1;
              c.rem_sel  = REM_CNT1;
              c.acc_clr  = 1'b1;
              state_next = S_SCAN;
            end
          end
          default: ;
        endcase
      end

      // wait while the slot finder's group registers and slot register settle on the current free map
      S_FIND: state_next = S_SLOT;

      S_SLOT: begin
        if (op == OP_INS_MID) begin
          c.rd_en    = 1'b1;
          c.cur_load = 1'b1;
          c.rem_load = 1'b1;
          c.rem_sel  = REM_POS2;
          state_next = S_WALK;
        end else begin
          state_next = S_INS_A;
        end
      end

      S_WALK: begin
        if (st.rem_zero) begin
          case (op)
            OP_INS_MID: state_next = S_INS_A;
            OP_DEL_LAST: begin
              c.upd      = UPD_DEL_TAIL;
              state_next = S_LINK_TH;
            end
            default: begin
              // fetch the victim's successor, keep cur on its predecessor
              c.aux_load = 1'b1;
              c.rd_en    = 1'b1;
              c.rd_sel   = RD_LINK;
              state_next = S_DEL_T;
            end
          endcase
        end else begin
          c.rd_en    = 1'b1;
          c.rd_sel   = RD_LINK;
          c.cur_load = 1'b1;
          c.rem_dec  = 1'b1;
        end
      end

      S_DEL_T: begin
        c.lw_en    = 1'b1;
        c.la_sel   = LA_CUR;
        c.ld_sel   = LD_RDLINK;
        c.upd      = UPD_DEL_MID;
        state_next = S_EMIT;
      end

      S_INS_A: begin
        c.vw_en = 1'b1;
        c.lw_en = 1'b1;
        case (op)
          OP_INS_LAST: begin
            c.la_sel = LA_TAIL;
            c.ld_sel = LD_SLOT;
          end
          OP_INS_MID: begin
            c.la_sel = LA_SLOT;
            c.ld_sel = LD_RDLINK;
          end
          default: begin
            c.la_sel = LA_SLOT;
            c.ld_sel = LD_HEAD;
          end
        endcase
        state_next = S_INS_B;
      end

      S_INS_B: begin
        case (op)
          OP_INS_LAST: begin
            c.upd      = UPD_INS_LAST;
            state_next = S_LINK_TH;
          end
          OP_INS_MID: begin
            c.lw_en    = 1'b1;
            c.la_sel   = LA_CUR;
            c.ld_sel   = LD_SLOT;
            c.upd      = UPD_INS_MID;
            state_next = S_EMIT;
          end
          default: begin
            c.upd      = UPD_INS_FIRST;
            state_next = S_LINK_TH;
          end
        endcase
      end

      // close the ring: tail points at head
      S_LINK_TH: begin
        c.lw_en    = 1'b1;
        c.la_sel   = LA_TAIL;
        c.ld_sel   = LD_HEAD;
        state_next = S_EMIT;
      end

      S_DROP_HEAD: begin
        c.upd      = UPD_DEL_HEAD;
        state_next = S_LINK_TH;
      end

      S_SCAN: begin
        c.acc_step = 1'b1;
        if (st.rem_zero) begin
          em_sel_next = (st.cmd == CMD_SEARCH) ? EM_FOUND : EM_ACC;
          state_next  = S_EMIT;
        end else begin
          c.rd_en    = 1'b1;
          c.rd_sel   = RD_LINK;
          c.cur_load = 1'b1;
          c.rem_dec  = 1'b1;
        end
      end

      S_DUMP: begin
        if (st.out_free) begin
          c.emit      = 1'b1;
          c.em_sel    = EM_DUMP;
          c.em_status = ST_OK;
          c.em_last   = st.rem_zero;
          if (st.rem_zero) begin
            state_next = S_IDLE;
          end else begin
            c.rd_en    = 1'b1;
            c.rd_sel   = RD_LINK;
            c.cur_load = 1'b1;
            c.rem_dec  = 1'b1;
          end
        end
      end

      S_EMIT: begin
        if (st.out_free) begin
          c.emit      = 1'b1;
          c.em_sel    = em_sel;
          c.em_status = em_st;
          c.em_last   = 1'b1;
          state_next  = S_IDLE;
        end
      end

      default: state_next = S_IDLE;
    endcase
  end

endmodule

// ----- hw/rtl/ordered_list_engine.sv -----
// Top level of the ordered list engine: circular linked list in a node store.
//
//  channel | direction | transfer when          | payload
//  in      | input     | in_valid & in_ready    | command, value, position
//  out     | output    | out_valid & out_ready  | result_value, found, status, last_result
//
// One command at a time; in_ready is high only while the controller is idle.
// Front/back insert, front delete, count query, rejected commands and deleting
// the only entry need no walk of the list. Positional edits, delete-last, dump
// and other queries walk the link store one read per cycle. A dump holds its
// walk while out_ready is low; a result may wait in the output register while
// the next command is taken. Synchronous reset; no clearing pass.
`timescale 1ns / 1ps
module ordered_list_engine (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic [olist_pkg::CMD_W-1:0]         command,
  input  logic signed [olist_pkg::VAL_W-1:0]  value,
  input  logic [olist_pkg::POS_W-1:0]         position,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic signed [olist_pkg::VAL_W-1:0]  result_value,
  output logic                                found,
  output logic [1:0]                          status,
  output logic                                last_result
);
  import olist_pkg::*;

  dp_cmd_t  c;
  dp_stat_t st;

  olist_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .st       (st),
    .c        (c)
  );

  olist_dp u_dp (
    .clk          (clk),
    .rst          (rst),
    .c            (c),
    .st           (st),
    .command      (command),
    .value        (value),
    .position     (position),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .result_value (result_value),
    .found        (found),
    .status       (status),
    .last_result  (last_result)
  );

endmodule

// ----- hw/rtl/olist_chk.sv -----
// Port-level checker for the ordered list engine, bound to the top level.
`timescale 1ns / 1ps
module olist_chk (
  input logic                               clk,
  input logic                               rst,
  input logic                               in_valid,
  input logic                               in_ready,
  input logic                               out_valid,
  input logic                               out_ready,
  input logic signed [olist_pkg::VAL_W-1:0] result_value,
  input logic                               found,
  input logic [1:0]                         status,
  input logic                               last_result
);
  import olist_pkg::*;

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped while stalled");

  a_found_ok: assert property (@(posedge clk) disable iff (rst)
    out_valid && found |-> (status == ST_OK) && last_result)
    else $error("found set on a non-ok or non-final result");

  a_err_single: assert property (@(posedge clk) disable iff (rst)
    out_valid && (status != ST_OK) |-> last_result && (result_value == '0) && !found)
    else $error("error result is not a single zero result");

  a_reset_idle: assert property (@(posedge clk)
    rst |=> !out_valid && in_ready)
    else $error("block not idle after reset");

  // one command at a time
  a_one_cmd: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("second transfer taken while busy");

endmodule

bind ordered_list_engine olist_chk u_olist_chk (
  .clk          (clk),
  .rst          (rst),
  .in_valid     (in_valid),
  .in_ready     (in_ready),
  .out_valid    (out_valid),
  .out_ready    (out_ready),
  .result_value (result_value),
  .found        (found),
  .status       (status),
  .last_result  (last_result)
);

// ----- test/list_checker.sv -----
// Checker for the ordered list engine: mirrors the list, predicts results, compares.
`timescale 1ns / 1ps
module list_checker
  import olist_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     in_valid,
  input  logic                     in_ready,
  input  logic [CMD_W-1:0]         command,
  input  logic signed [VAL_W-1:0]  value,
  input  logic [POS_W-1:0]         position,
  input  logic                     out_valid,
  input  logic                     out_ready,
  input  logic signed [VAL_W-1:0]  result_value,
  input  logic                     found,
  input  logic [1:0]               status,
  input  logic                     last_result,
  output int                       errors,
  output int                       pending
);

  typedef struct packed {
    logic signed [VAL_W-1:0] rv;
    logic                    fnd;
    status_e                 st;
    logic                    last;
  } result_t;

  // list contents in order; slot allocation does not affect visible results
  logic signed [VAL_W-1:0] list_q[$];
  result_t                 expected_q[$];

  assign pending = expected_q.size();

  task automatic report(input string what);
    errors++;
    $display("%0t mismatch: %s", $realtime, what);
  endtask

  function automatic result_t mk(input logic signed [VAL_W-1:0] rv, input logic fnd,
                                 input status_e st, input logic last);
    result_t r;
    r.rv = rv; r.fnd = fnd; r.st = st; r.last = last;
    return r;
  endfunction

  task automatic predict_command(input logic [CMD_W-1:0] cmd,
                                 input logic signed [VAL_W-1:0] v,
                                 input logic [POS_W-1:0] pos);
    int n;
    logic signed [VAL_W-1:0] acc;
    n = list_q.size();
    case (cmd)
      CMD_INS_FIRST, CMD_INS_LAST: begin
        if (n >= DEPTH) expected_q.push_back(mk(0, 0, ST_FULL, 1));
        else begin
          if (cmd == CMD_INS_FIRST) list_q.push_front(v);
          else list_q.push_back(v);
          expected_q.push_back(mk(0, 0, ST_OK, 1));
        end
      end
      CMD_INS_POS: begin
        if (pos < 1 || pos > n + 1) expected_q.push_back(mk(0, 0, ST_BADPOS, 1));
        else if (n >= DEPTH) expected_q.push_back(mk(0, 0, ST_FULL, 1));
        else begin
          list_q.insert(pos - 1, v);
          expected_q.push_back(mk(0, 0, ST_OK, 1));
        end
      end
      CMD_DEL_FIRST, CMD_DEL_LAST, CMD_DEL_POS: begin
        if (n == 0) expected_q.push_back(mk(0, 0, ST_EMPTY, 1));
        else if (cmd == CMD_DEL_POS && (pos < 1 || pos > n))
          expected_q.push_back(mk(0, 0, ST_BADPOS, 1));
        else begin
          if (cmd == CMD_DEL_FIRST) void'(list_q.pop_front());
          else if (cmd == CMD_DEL_LAST) void'(list_q.pop_back());
          else list_q.delete(pos - 1);
          expected_q.push_back(mk(0, 0, ST_OK, 1));
        end
      end
      CMD_UNUSED: expected_q.push_back(mk(0, 0, ST_OK, 1));
      default: begin
        if (n == 0) expected_q.push_back(mk(0, 0, ST_EMPTY, 1));
        else if (cmd == CMD_DUMP) begin
          for (int i = 0; i < n; i++)
            expected_q.push_back(mk(list_q[i], 0, ST_OK, i == n - 1));
        end else begin
          acc = (cmd == CMD_MAX || cmd == CMD_MIN) ? list_q[0] : 0;
          foreach (list_q[i]) begin
            case (cmd)
              CMD_COUNT:  acc++;
              CMD_EVEN:   if (!list_q[i][0]) acc++;
              CMD_ODD:    if (list_q[i][0]) acc++;
              CMD_SUM:    acc += list_q[i];
              CMD_MAX:    if (list_q[i] > acc) acc = list_q[i];
              CMD_MIN:    if (list_q[i] < acc) acc = list_q[i];
              default:    if (list_q[i] == v) acc++;
            endcase
          end
          if (cmd == CMD_SEARCH) expected_q.push_back(mk(0, acc != 0, ST_OK, 1));
          else expected_q.push_back(mk(acc, 0, ST_OK, 1));
        end
      end
    endcase
  endtask

  initial errors = 0;

  always @(posedge clk) begin
    if (!rst) begin
      // output side first: a result leaving now belongs to an earlier command
      if (out_valid && out_ready) begin
        if (expected_q.size() == 0) report("result with nothing expected");
        else begin
          result_t e;
          e = expected_q.pop_front();
          if (result_value !== e.rv)
            report($sformatf("result_value %0d, want %0d", result_value, e.rv));
          if (found !== e.fnd) report($sformatf("found %b, want %b", found, e.fnd));
          if (status !== e.st) report($sformatf("status %0d, want %0d", status, e.st));
          if (last_result !== e.last)
            report($sformatf("last_result %b, want %b", last_result, e.last));
        end
      end
      if (in_valid && in_ready) predict_command(command, value, position);
    end
  end

endmodule

// ----- test/testbench.sv -----
// Top of the ordered list engine testbench: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps
module testbench;
  import olist_pkg::*;

  logic clk, rst;
  logic in_valid, in_ready, out_valid, out_ready;
  logic [CMD_W-1:0] command;
  logic signed [VAL_W-1:0] value;
  logic [POS_W-1:0] position;
  logic signed [VAL_W-1:0] result_value;
  logic found, last_result;
  logic [1:0] status;
  int errors, pending;
  int list_len;    // tracked here to shape stimulus
  int burst_left;
  int stall_mode;

  ordered_list_engine uut (.*);

  list_checker chk (.*);

  initial begin
    clk = 0;
    forever #1 clk = ~clk;
  end

  initial begin
    #4000000;
    $display("Regression FAIL");
    $finish;
  end

  // receiver: stall pattern changes phase now and then, with open stretches
  initial begin
    out_ready = 0;
    stall_mode = 0;
    forever begin
      @(negedge clk);
      if ($urandom_range(0, 40) == 0) stall_mode = $urandom_range(0, 3);
      case (stall_mode)
        0: out_ready <= 1;
        1: out_ready <= ($urandom_range(0, 3) != 0);
        2: out_ready <= ($urandom_range(0, 3) == 0);
        default: out_ready <= 1'($urandom_range(0, 1));
      endcase
    end
  end

  // in_valid stays high between transfers of a burst; it drops only for a gap
  task automatic send(input logic [CMD_W-1:0] c, input logic signed [VAL_W-1:0] v,
                      input logic [POS_W-1:0] p);
    int gap;
    if (burst_left == 0) begin
      gap = $urandom_range(0, 6);
      if (gap > 0) begin
        in_valid <= 0;
        repeat (gap) @(negedge clk);
      end
      burst_left = $urandom_range(1, 10);
    end
    burst_left--;
    in_valid <= 1; command <= c; value <= v; position <= p;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    @(negedge clk);
    case (c)
      CMD_INS_FIRST, CMD_INS_LAST: if (list_len < DEPTH) list_len++;
      CMD_INS_POS: if (p >= 1 && p <= list_len + 1 && list_len < DEPTH) list_len++;
      CMD_DEL_FIRST, CMD_DEL_LAST: if (list_len > 0) list_len--;
      CMD_DEL_POS: if (list_len > 0 && p >= 1 && p <= list_len) list_len--;
      default: ;
    endcase
  endtask

  function automatic logic signed [VAL_W-1:0] rand_value();
    case ($urandom_range(0, 4))
      0: return 32'sh7FFFFFFF;
      1: return 32'sh80000000;
      2: return $urandom_range(0, 7) - 3;
      default: return $urandom;
    endcase
  endfunction

  task automatic send_queries();
    for (int c = CMD_DUMP; c <= CMD_FREQ; c++) send(CMD_W'(c), rand_value(), 0);
  endtask

  initial begin
    logic [CMD_W-1:0] c;
    int k;
    rst = 1; in_valid = 0; command = 0; value = 0; position = 0;
    list_len = 0; burst_left = 0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst = 0;

    // empty list: every query and delete
    send_queries();
    send(CMD_DEL_FIRST, 0, 0);
    send(CMD_DEL_LAST, 0, 0);
    send(CMD_DEL_POS, 0, 127);
    send(CMD_UNUSED, 32'sh7FFFFFFF, 127);
    send(CMD_INS_POS, 5, 0);
    send(CMD_INS_POS, 5, 2);
    send(CMD_INS_POS, 32'sh80000000, 1);
    send(CMD_DEL_FIRST, 0, 0);          // only entry removed
    send(CMD_INS_LAST, 32'sh7FFFFFFF, 0);
    send(CMD_INS_FIRST, -1, 0);
    send(CMD_INS_POS, 2, 2);
    send(CMD_DEL_POS, 0, 0);
    send(CMD_DEL_POS, 0, 4);
    send(CMD_DEL_POS, 0, 3);            // last position
    send(CMD_INS_LAST, 2, 0);
    send_queries();

    // fill to full, exercise full status
    while (list_len < DEPTH) send(CMD_W'($urandom_range(0, 1)), rand_value(), 0);
    send(CMD_INS_FIRST, 1, 0);
    send(CMD_INS_POS, 1, 65);
    send(CMD_INS_POS, 1, 66);
    send_queries();
    send(CMD_DEL_POS, 0, 64);
    send(CMD_INS_POS, 9, 33);
    send(CMD_DEL_POS, 0, 32);

    // random mix: edits on a large list turn into deletes, some out-of-range noise
    for (int i = 0; i < 15; i++) begin
      k = $urandom_range(0, 99);
      if (k < 50) begin
        c = CMD_W'($urandom_range(CMD_INS_FIRST, CMD_DEL_POS));
        if (list_len > 12 && c <= CMD_INS_POS) c = c + CMD_W'(3);
        send(c, rand_value(),
             (k < 45) ? POS_W'($urandom_range(1, list_len + 1)) : POS_W'($urandom));
      end else if (k < 95) begin
        send(CMD_W'($urandom_range(CMD_DUMP, CMD_FREQ)), rand_value(), POS_W'($urandom));
      end else begin
        send(CMD_W'($urandom), $urandom, POS_W'($urandom));
      end
    end
    in_valid <= 0;

    while (pending != 0) @(posedge clk);
    repeat (80) @(posedge clk);
    if (errors == 0) $display("Regression PASS");
    else $display("Regression FAIL");
    $finish;
  end

endmodule
